/* rtl/utf8d_pkg.sv */
// shared types and constants for the utf-8 to utf-16 decoder
`default_nettype none

package utf8d_pkg;

	typedef enum logic [1:0] {
		KIND_UNIT = 2'd0,
		KIND_ERROR = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_BAD_LEAD = 3'd1,
		ERR_BAD_CONT = 3'd2,
		ERR_OVERLONG = 3'd3,
		ERR_INVALID = 3'd4,
		ERR_TRUNCATED = 3'd5
	} err_t;

	// pending check on the second byte of a sequence, set by the lead byte
	typedef enum logic [1:0] {
		CHK_NONE = 2'd0,
		CHK_LEAD_C0 = 2'd1,
		CHK_LEAD_E0 = 2'd2,
		CHK_LEAD_F0 = 2'd3
	} chk_t;

	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;
	localparam logic [7:0] LEAD2_OVERLONG_MASK = 8'h1E;

	localparam logic [20:0] MAX_POINT = 21'h10FFFF;
	localparam logic [20:0] BMP_MAX = 21'h00FFFF;
	localparam logic [20:0] SUPP_BASE = 21'h010000;
	localparam logic [20:0] SURR_LOW_FIRST = 21'h00D800;
	localparam logic [20:0] SURR_LAST = 21'h00DFFF;
	localparam logic [20:0] HIGH_SURR_BASE = 21'h00D800;
	localparam logic [20:0] LOW_SURR_BASE = 21'h00DC00;

	typedef struct packed {
		kind_t kind;
		logic [20:0] unit;
		err_t err;
	} slot_t;

	// all results caused by one byte: units first, then error, then summary
	typedef struct packed {
		logic [1:0] count;
		slot_t [2:0] slot;
		logic [31:0] unit_count;
		logic [31:0] bytes_accepted;
	} bundle_t;

endpackage

`default_nettype wire

/* rtl/utf8d_core.sv */
// per-string decode state and the combinational byte decoder
`default_nettype none

module utf8d_core #(
	parameter int COUNT_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic utf16_mode,
	input wire logic advance,
	input wire logic [7:0] data_byte,
	input wire logic end_of_input,
	output utf8d_pkg::bundle_t bundle
);

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	logic [1:0] pend_q, pend_d;
	logic [20:0] point_q, point_d;
	utf8d_pkg::chk_t chk_q, chk_d;
	logic [2:0] len_q, len_d;
	logic err_latched_q, err_latched_d;
	logic [COUNT_WIDTH-1:0] units_q, units_new;
	logic [COUNT_WIDTH-1:0] bytes_q, bytes_new;

	utf8d_pkg::err_t err;
	logic emit;
	logic [20:0] cp;
	logic [2:0] emit_len;
	logic [2:0] lead_len;

	logic invalid_cp;
	logic pair;
	logic [20:0] offset;
	logic [20:0] unit_hi, unit_lo;
	logic [COUNT_WIDTH:0] units_sum, bytes_sum;
	logic [31:0] units_out, bytes_out;

	always_comb begin
		pend_d = pend_q;
		point_d = point_q;
		chk_d = chk_q;
		len_d = len_q;
		err_latched_d = err_latched_q;
		err = utf8d_pkg::ERR_NONE;
		emit = 1'b0;
		cp = '0;
		emit_len = len_q;
		lead_len = 3'd0;
		if (!err_latched_q) begin
			if (pend_q == 2'd0) begin
				chk_d = utf8d_pkg::CHK_NONE;
				if (!data_byte[7]) begin
					lead_len = 3'd1;
					point_d = 21'(data_byte);
				end else if ((data_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE) begin
					lead_len = 3'd2;
					point_d = 21'(data_byte[4:0]);
					if ((data_byte & utf8d_pkg::LEAD2_OVERLONG_MASK) == 8'd0) begin
						chk_d = utf8d_pkg::CHK_LEAD_C0;
					end
				end else if ((data_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE) begin
					lead_len = 3'd3;
					point_d = 21'(data_byte[3:0]);
					if (data_byte == utf8d_pkg::LEAD3_CODE) begin
						chk_d = utf8d_pkg::CHK_LEAD_E0;
					end
				end else if ((data_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE) begin
					lead_len = 3'd4;
					point_d = 21'(data_byte[2:0]);
					if (data_byte == utf8d_pkg::LEAD4_CODE) begin
						chk_d = utf8d_pkg::CHK_LEAD_F0;
					end
				end
				if (lead_len == 3'd0) begin
					err = utf8d_pkg::ERR_BAD_LEAD;
				end else if (lead_len > 3'd1 && end_of_input) begin
					err = utf8d_pkg::ERR_TRUNCATED;
				end else begin
					len_d = lead_len;
					pend_d = 2'(lead_len - 3'd1);
					if (lead_len == 3'd1) begin
						emit = 1'b1;
						cp = point_d;
						emit_len = lead_len;
					end
				end
			end else begin
				if (end_of_input && pend_q > 2'd1) begin
					err = utf8d_pkg::ERR_TRUNCATED;
				end else if (data_byte[7:6] != 2'b10) begin
					err = utf8d_pkg::ERR_BAD_CONT;
				end else begin
					if (chk_q == utf8d_pkg::CHK_LEAD_C0 ||
					    (chk_q == utf8d_pkg::CHK_LEAD_E0 && !data_byte[5]) ||
					    (chk_q == utf8d_pkg::CHK_LEAD_F0 && data_byte[5:4] == 2'b00)) begin
						err = utf8d_pkg::ERR_OVERLONG;
					end
					chk_d = utf8d_pkg::CHK_NONE;
					if (err == utf8d_pkg::ERR_NONE) begin
						point_d = {point_q[14:0], data_byte[5:0]};
						pend_d = pend_q - 2'd1;
						if (pend_q == 2'd1) begin
							emit = 1'b1;
							cp = point_d;
							emit_len = len_q;
						end
					end
				end
			end
			// surrogates and points past the unicode range are rejected once complete
			if (emit && invalid_cp) begin
				err = utf8d_pkg::ERR_INVALID;
				emit = 1'b0;
			end
			if (err != utf8d_pkg::ERR_NONE) begin
				err_latched_d = 1'b1;
				pend_d = 2'd0;
				chk_d = utf8d_pkg::CHK_NONE;
			end
		end
	end

	assign invalid_cp = (cp > utf8d_pkg::MAX_POINT) ||
	                    (cp >= utf8d_pkg::SURR_LOW_FIRST && cp <= utf8d_pkg::SURR_LAST);
	assign pair = utf16_mode && (cp > utf8d_pkg::BMP_MAX);
	assign offset = cp - utf8d_pkg::SUPP_BASE;
	assign unit_hi = utf8d_pkg::HIGH_SURR_BASE + 21'(offset[19:10]);
	assign unit_lo = utf8d_pkg::LOW_SURR_BASE + 21'(offset[9:0]);

	// saturating counters
	assign units_sum = {1'b0, units_q} + (COUNT_WIDTH+1)'(pair ? 2'd2 : 2'd1);
	assign bytes_sum = {1'b0, bytes_q} + (COUNT_WIDTH+1)'(emit_len);
	assign units_new = !emit ? units_q : (units_sum[COUNT_WIDTH] ? CNT_MAX :
	                   units_sum[COUNT_WIDTH-1:0]);
	assign bytes_new = !emit ? bytes_q : (bytes_sum[COUNT_WIDTH] ? CNT_MAX :
	                   bytes_sum[COUNT_WIDTH-1:0]);

	if (COUNT_WIDTH > 32) begin : g_clamp
		assign units_out = (|units_new[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : units_new[31:0];
		assign bytes_out = (|bytes_new[COUNT_WIDTH-1:32]) ? 32'hFFFF_FFFF : bytes_new[31:0];
	end else begin : g_extend
		assign units_out = 32'(units_new);
		assign bytes_out = 32'(bytes_new);
	end

	always_comb begin
		logic [1:0] n;
		n = 2'd0;
		bundle = '0;
		if (emit) begin
			bundle.slot[0].kind = utf8d_pkg::KIND_UNIT;
			bundle.slot[0].unit = pair ? unit_hi : cp;
			bundle.slot[0].err = utf8d_pkg::ERR_NONE;
			n = 2'd1;
			if (pair) begin
				bundle.slot[1].kind = utf8d_pkg::KIND_UNIT;
				bundle.slot[1].unit = unit_lo;
				bundle.slot[1].err = utf8d_pkg::ERR_NONE;
				n = 2'd2;
			end
		end
		if (err != utf8d_pkg::ERR_NONE) begin
			bundle.slot[n].kind = utf8d_pkg::KIND_ERROR;
			bundle.slot[n].unit = '0;
			bundle.slot[n].err = err;
			n = n + 2'd1;
		end
		if (end_of_input) begin
			bundle.slot[n].kind = utf8d_pkg::KIND_SUMMARY;
			bundle.slot[n].unit = '0;
			bundle.slot[n].err = utf8d_pkg::ERR_NONE;
			n = n + 2'd1;
		end
		bundle.count = n;
		bundle.unit_count = units_out;
		bundle.bytes_accepted = bytes_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			point_q <= '0;
			chk_q <= utf8d_pkg::CHK_NONE;
			len_q <= '0;
			err_latched_q <= 1'b0;
			units_q <= '0;
			bytes_q <= '0;
		end else if (advance) begin
			if (end_of_input) begin
				// end of string clears everything for the next one
				pend_q <= '0;
				point_q <= '0;
				chk_q <= utf8d_pkg::CHK_NONE;
				len_q <= '0;
				err_latched_q <= 1'b0;
				units_q <= '0;
				bytes_q <= '0;
			end else begin
				pend_q <= pend_d;
				point_q <= point_d;
				chk_q <= chk_d;
				len_q <= len_d;
				err_latched_q <= err_latched_d;
				units_q <= units_new;
				bytes_q <= bytes_new;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/utf8d_outq.sv */
// result register that hands out the results of one byte one per cycle while out_ready is high
`default_nettype none

module utf8d_outq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load,
	input wire utf8d_pkg::bundle_t bundle_in,
	output logic can_load,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [20:0] code_unit,
	output logic [2:0] error_code,
	output logic [31:0] unit_count,
	output logic [31:0] bytes_accepted,
	output logic last_of_run
);

	utf8d_pkg::bundle_t bun_q;
	logic [1:0] idx_q;
	logic busy_q;
	utf8d_pkg::slot_t cur;
	logic last;
	logic take;

	assign cur = bun_q.slot[idx_q];
	assign last = (idx_q == bun_q.count - 2'd1);
	assign take = busy_q && out_ready;
	assign can_load = !busy_q || (out_ready && last);

	assign out_valid = busy_q;
	assign kind = cur.kind;
	assign code_unit = cur.unit;
	assign error_code = cur.err;
	assign unit_count = (cur.kind == utf8d_pkg::KIND_SUMMARY) ? bun_q.unit_count : 32'd0;
	assign bytes_accepted = (cur.kind == utf8d_pkg::KIND_SUMMARY) ? bun_q.bytes_accepted : 32'd0;
	assign last_of_run = last;

	always_ff @(posedge clk) begin
		if (load) begin
			bun_q <= bundle_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/utf8_to_utf16_decoder.sv */
// Top level of the UTF-8 to UTF-16/UTF-32 decoder. A byte request is taken into an input
// register, decoded against the per-string state in one pass and its results (up to three:
// one or two code units, an error report, an end-of-string summary) are loaded into the
// result register, from which they leave one per cycle while out_ready is high. A byte is
// accepted every clock while out_ready is high and each byte yields at most one result; a
// byte with more results holds the result register until all are taken. The first result
// leaves the result register after its byte has passed the input register and the decoder.
// Counters are COUNT_WIDTH bits wide and saturate; reported counts clamp at 32 bits.
// utf16_mode may only be written while the block is idle.
`default_nettype none

module utf8_to_utf16_decoder #(
	parameter int COUNT_WIDTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [7:0] data_byte,
	input wire logic end_of_input,
	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] kind,
	output logic [20:0] code_unit,
	output logic [2:0] error_code,
	output logic [31:0] unit_count,
	output logic [31:0] bytes_accepted,
	output logic last_of_run
);

	logic utf16_mode_q;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic eoi_s1;
	logic advance;
	logic can_load;
	utf8d_pkg::bundle_t bundle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_mode_q <= 1'b1;
		end else if (cfg_we) begin
			utf16_mode_q <= cfg_wdata;
		end
	end

	// a byte that gives no result never waits for the result register
	assign advance = valid_s1 && (bundle.count == 2'd0 || can_load);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			eoi_s1 <= end_of_input;
		end
	end

	utf8d_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.utf16_mode(utf16_mode_q),
		.advance(advance),
		.data_byte(byte_s1),
		.end_of_input(eoi_s1),
		.bundle(bundle)
	);

	utf8d_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.load(advance && bundle.count != 2'd0),
		.bundle_in(bundle),
		.can_load(can_load),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.code_unit(code_unit),
		.error_code(error_code),
		.unit_count(unit_count),
		.bytes_accepted(bytes_accepted),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

/* test/utf8_to_utf16_decoder_tb.sv */
// testbench for the utf-8 to utf-16/utf-32 decoder: directed strings, random strings, stalls
`default_nettype none

module utf8_to_utf16_decoder_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_BYTES = 80;

	typedef struct packed {
		utf8d_pkg::kind_t kind;
		logic [20:0] unit;
		utf8d_pkg::err_t err;
		logic [31:0] units;
		logic [31:0] nbytes;
		logic last;
	} decoded_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] data_byte = 8'h00;
	logic end_of_input = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic [20:0] code_unit;
	logic [2:0] error_code;
	logic [31:0] unit_count;
	logic [31:0] bytes_accepted;
	logic last_of_run;

	utf8_to_utf16_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_input(end_of_input),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.code_unit(code_unit),
		.error_code(error_code),
		.unit_count(unit_count),
		.bytes_accepted(bytes_accepted),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	// decoder copy kept by the testbench
	logic model_utf16 = 1'b1;
	logic [1:0] dec_pending = 2'd0;
	logic [20:0] dec_point = 21'd0;
	utf8d_pkg::chk_t dec_check = utf8d_pkg::CHK_NONE;
	logic [2:0] dec_len = 3'd0;
	logic dec_failed = 1'b0;
	logic [31:0] dec_units = 32'd0;
	logic [31:0] dec_bytes = 32'd0;

	decoded_result_t expected_results[$];
	logic [7:0] text_q[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int live_bytes = 0;
	int strings_sent = 0;
	int cycle_count = 0;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] inc);
		logic [32:0] sum;
		sum = {1'b0, a} + {1'b0, inc};
		return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	task automatic queue_result(input utf8d_pkg::kind_t k, input logic [20:0] u,
			input utf8d_pkg::err_t e, input logic [31:0] n_units, input logic [31:0] n_bytes);
		decoded_result_t r;
		r.kind = k;
		r.unit = u;
		r.err = e;
		r.units = n_units;
		r.nbytes = n_bytes;
		r.last = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic emit_point(output utf8d_pkg::err_t e);
		logic [20:0] off;
		e = utf8d_pkg::ERR_NONE;
		off = dec_point - utf8d_pkg::SUPP_BASE;
		if (dec_point > utf8d_pkg::MAX_POINT || (dec_point >= utf8d_pkg::SURR_LOW_FIRST &&
				dec_point <= utf8d_pkg::SURR_LAST)) begin
			e = utf8d_pkg::ERR_INVALID;
		end else if (model_utf16 && dec_point > utf8d_pkg::BMP_MAX) begin
			queue_result(utf8d_pkg::KIND_UNIT, utf8d_pkg::HIGH_SURR_BASE + {11'd0, off[19:10]},
				utf8d_pkg::ERR_NONE, 32'd0, 32'd0);
			queue_result(utf8d_pkg::KIND_UNIT, utf8d_pkg::LOW_SURR_BASE + {11'd0, off[9:0]},
				utf8d_pkg::ERR_NONE, 32'd0, 32'd0);
			dec_units = sat_add(dec_units, 32'd2);
		end else begin
			queue_result(utf8d_pkg::KIND_UNIT, dec_point, utf8d_pkg::ERR_NONE, 32'd0, 32'd0);
			dec_units = sat_add(dec_units, 32'd1);
		end
		if (e == utf8d_pkg::ERR_NONE)
			dec_bytes = sat_add(dec_bytes, {29'd0, dec_len});
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic eoi);
		logic [2:0] len;
		utf8d_pkg::err_t err;
		int first;
		decoded_result_t r;
		first = expected_results.size();
		err = utf8d_pkg::ERR_NONE;
		live_bytes++;
		if (!dec_failed) begin
			if (dec_pending == 2'd0) begin
				len = 3'd0;
				dec_check = utf8d_pkg::CHK_NONE;
				if (b < 8'h80) begin
					len = 3'd1;
					dec_point = {13'd0, b};
				end else if ((b & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_CODE) begin
					len = 3'd2;
					dec_point = {16'd0, b[4:0]};
					if ((b & utf8d_pkg::LEAD2_OVERLONG_MASK) == 8'h00)
						dec_check = utf8d_pkg::CHK_LEAD_C0;
				end else if ((b & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_CODE) begin
					len = 3'd3;
					dec_point = {17'd0, b[3:0]};
					if (b == 8'hE0)
						dec_check = utf8d_pkg::CHK_LEAD_E0;
				end else if ((b & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_CODE) begin
					len = 3'd4;
					dec_point = {18'd0, b[2:0]};
					if (b == 8'hF0)
						dec_check = utf8d_pkg::CHK_LEAD_F0;
				end
				if (len == 3'd0) begin
					err = utf8d_pkg::ERR_BAD_LEAD;
				end else if (len > 3'd1 && eoi) begin
					err = utf8d_pkg::ERR_TRUNCATED;
				end else begin
					dec_len = len;
					dec_pending = 2'(len - 3'd1);
					if (len == 3'd1)
						emit_point(err);
				end
			end else begin
				if (eoi && dec_pending > 2'd1) begin
					err = utf8d_pkg::ERR_TRUNCATED;
				end else if (b[7:6] != 2'b10) begin
					err = utf8d_pkg::ERR_BAD_CONT;
				end else begin
					if (dec_check == utf8d_pkg::CHK_LEAD_C0 ||
							(dec_check == utf8d_pkg::CHK_LEAD_E0 && !b[5]) ||
							(dec_check == utf8d_pkg::CHK_LEAD_F0 && b[5:4] == 2'b00))
						err = utf8d_pkg::ERR_OVERLONG;
					dec_check = utf8d_pkg::CHK_NONE;
					if (err == utf8d_pkg::ERR_NONE) begin
						dec_point = {dec_point[14:0], b[5:0]};
						dec_pending = dec_pending - 2'd1;
						if (dec_pending == 2'd0)
							emit_point(err);
					end
				end
			end
			if (err != utf8d_pkg::ERR_NONE) begin
				queue_result(utf8d_pkg::KIND_ERROR, 21'd0, err, 32'd0, 32'd0);
				dec_failed = 1'b1;
				dec_pending = 2'd0;
				dec_check = utf8d_pkg::CHK_NONE;
			end
		end
		if (eoi) begin
			queue_result(utf8d_pkg::KIND_SUMMARY, 21'd0, utf8d_pkg::ERR_NONE, dec_units,
				dec_bytes);
			dec_pending = 2'd0;
			dec_point = 21'd0;
			dec_check = utf8d_pkg::CHK_NONE;
			dec_len = 3'd0;
			dec_failed = 1'b0;
			dec_units = 32'd0;
			dec_bytes = 32'd0;
		end
		if (expected_results.size() > first) begin
			r = expected_results.pop_back();
			r.last = 1'b1;
			expected_results.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// requests and config writes feed the model, results are checked in order
	always @(posedge clk) begin : track
		decoded_result_t r;
		if (arst_n) begin
			if (in_valid && in_ready)
				decode_byte(data_byte, end_of_input);
			if (cfg_we)
				model_utf16 = cfg_wdata;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: kind %0d unit %0h err %0d", kind, code_unit,
						error_code);
					mismatches++;
				end else begin
					r = expected_results.pop_front();
					check_field("kind", 32'(r.kind), 32'(kind));
					check_field("code_unit", 32'(r.unit), 32'(code_unit));
					check_field("error_code", 32'(r.err), 32'(error_code));
					check_field("unit_count", r.units, unit_count);
					check_field("bytes_accepted", r.nbytes, bytes_accepted);
					check_field("last_of_run", 32'(r.last), 32'(last_of_run));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: random stalls, or a long hold when asked
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_byte(text_q[i], i == text_q.size() - 1);
		strings_sent++;
		text_q.delete();
	endtask

	// wait first so the last accepted request is already in the model
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int point_length(input logic [20:0] cp);
		if (cp < 21'h80)
			return 1;
		if (cp < 21'h800)
			return 2;
		if (cp < 21'h10000)
			return 3;
		return 4;
	endfunction

	// length may exceed the minimum, which gives an overlong form
	task automatic push_encoded(input logic [20:0] cp, input int len);
		case (len)
			1: text_q.push_back({1'b0, cp[6:0]});
			2: begin
				text_q.push_back({3'b110, cp[10:6]});
				text_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				text_q.push_back({4'b1110, cp[15:12]});
				text_q.push_back({2'b10, cp[11:6]});
				text_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				text_q.push_back({5'b11110, cp[20:18]});
				text_q.push_back({2'b10, cp[17:12]});
				text_q.push_back({2'b10, cp[11:6]});
				text_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	function automatic logic [20:0] random_point(input int len);
		logic [20:0] cp;
		case (len)
			1: cp = 21'($urandom_range(21'h7F, 0));
			2: cp = 21'($urandom_range(21'h7FF, 21'h80));
			3: begin
				cp = 21'($urandom_range(21'hFFFF, 21'h800));
				if (cp >= utf8d_pkg::SURR_LOW_FIRST && cp <= utf8d_pkg::SURR_LAST)
					cp = cp - 21'h800;
			end
			default: cp = 21'($urandom_range(utf8d_pkg::MAX_POINT, utf8d_pkg::SUPP_BASE));
		endcase
		return cp;
	endfunction

	task automatic push_valid_char();
		logic [20:0] edges[10];
		logic [20:0] cp;
		int pick;
		edges = '{21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hE000, 21'hFFFF,
			21'h10000, 21'h10FFFF};
		pick = $urandom_range(9, 0);
		if (pick == 9)
			cp = edges[$urandom_range(9, 0)];
		else
			cp = random_point(pick / 2 < 1 ? 1 : (pick + 1) / 2);
		push_encoded(cp, point_length(cp));
	endtask

	task automatic push_noise(output bit ends_text);
		logic [20:0] cp;
		logic [7:0] b;
		int len;
		int keep;
		ends_text = 1'b0;
		case ($urandom_range(6, 0))
			0: text_q.push_back(8'($urandom_range(255, 0)));
			1: push_encoded(21'($urandom_range(utf8d_pkg::SURR_LAST, utf8d_pkg::SURR_LOW_FIRST)),
				3);
			2: begin
				len = $urandom_range(4, 2);
				cp = 21'($urandom_range(len == 2 ? 21'h7F : (len == 3 ? 21'h7FF : 21'hFFFF), 0));
				push_encoded(cp, len);
			end
			3: push_encoded(21'($urandom_range(21'h1FFFFF, 21'h110000)), 4);
			4: begin
				len = $urandom_range(4, 2);
				push_encoded(random_point(len), len);
				b = 8'($urandom_range(255, 0));
				if (b[7:6] == 2'b10)
					b[6] = 1'b1;
				text_q[text_q.size() - $urandom_range(len - 1, 1)] = b;
			end
			5: text_q.push_back({2'b10, 6'($urandom_range(63, 0))});
			default: begin
				// string ends inside a multibyte character
				len = $urandom_range(4, 2);
				push_encoded(random_point(len), len);
				keep = $urandom_range(len - 1, 1);
				repeat (len - keep) void'(text_q.pop_back());
				ends_text = 1'b1;
			end
		endcase
	endtask

	task automatic build_text();
		int nchars;
		int noise_at;
		bit noisy;
		bit stop;
		nchars = $urandom_range(8, 1);
		noisy = ($urandom_range(99, 0) < 30);
		noise_at = $urandom_range(nchars - 1, 0);
		stop = 1'b0;
		for (int i = 0; i < nchars && !stop; i++) begin
			if (noisy && i == noise_at)
				push_noise(stop);
			else
				push_valid_char();
		end
	endtask

	task automatic run_random_text(input int target);
		int start;
		start = live_bytes;
		while (live_bytes - start < target) begin
			build_text();
			send_text();
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		text_q = '{8'h00, 8'h7F};
		send_text();
		// largest code point, a surrogate pair in the reset mode
		text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text();
		text_q = '{8'hC0, 8'h80};
		send_text();
		// non-continuation where an overlong test is pending
		text_q = '{8'hC1, 8'h41};
		send_text();
		text_q = '{8'hE2, 8'h82};
		send_text();
		text_q = '{8'hF0};
		send_text();
		text_q = '{8'hFF};
		send_text();
		text_q = '{8'hF5, 8'h80, 8'h80, 8'h80};
		send_text();
		// bytes after an error are dropped until the end marker
		text_q = '{8'h80, 8'h41, 8'h42};
		send_text();
		text_q = '{8'hED, 8'hA0, 8'h80};
		send_text();
	endtask

	task automatic test_no_idle();
		write_mode(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random_text(PHASE_BYTES);
	endtask

	task automatic test_sender_idle();
		write_mode(1'b0);
		send_idle_pct = 77;
		recv_stall_pct = 0;
		run_random_text(PHASE_BYTES);
	endtask

	task automatic test_receiver_stall();
		write_mode(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		run_random_text(PHASE_BYTES);
	endtask

	task automatic test_both_idle();
		write_mode(1'b0);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		run_random_text(PHASE_BYTES);
	endtask

	task automatic test_output_hold();
		write_mode(1'b1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		repeat (10)
			push_encoded(random_point(4), 4);
		send_text();
		run_random_text(PHASE_BYTES);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_no_idle();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_output_hold();
		settle();
		$display("checked %0d results from %0d strings (%0d bytes) in both output modes",
			results_seen, strings_sent, live_bytes);
		$display("with free flow, input gaps, output stalls and a %0d-cycle output hold",
			HOLD_CYCLES);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* utf8_to_utf16_decoder.f */
rtl/utf8d_pkg.sv
rtl/utf8d_core.sv
rtl/utf8d_outq.sv
rtl/utf8_to_utf16_decoder.sv
test/utf8_to_utf16_decoder_tb.sv
